/* hdl/backlight_sleep_wake_controller_macros.svh */
// Assertion macros used by the backlight sleep/wake controller checker.
`ifndef BACKLIGHT_SLEEP_WAKE_CONTROLLER_MACROS_SVH
`define BACKLIGHT_SLEEP_WAKE_CONTROLLER_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define BSWC_ASSERT_RST(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define BSWC_ASSERT(lbl, clk_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

/* hdl/bswc_pkg.sv */
// Types, constants and packing helpers for the backlight sleep/wake controller.
`default_nettype none

package bswc_pkg;

	// Configuration register indexes
	localparam logic [0:0] CFG_SLEEP_SECONDS     = 1'b0;
	localparam logic [0:0] CFG_MOTION_TIMEOUT_MS = 1'b1;

	localparam int CFG_DATA_W   = 24;
	localparam int SLEEP_S_W    = 16;
	localparam int SLEEP_MS_W   = 26;
	localparam int TIMEOUT_W    = 24;
	localparam int ELAPSED_W    = 10;
	localparam int LIGHT_W      = 12;
	localparam int LEVEL_W      = 13;
	localparam int IN_TDATA_W   = 32;
	localparam int OUT_TDATA_W  = 24;

	typedef logic [SLEEP_MS_W-1:0] sleep_ms_t;
	typedef logic [TIMEOUT_W-1:0]  timeout_t;
	typedef logic [LEVEL_W-1:0]    level_t;

	localparam sleep_ms_t MS_PER_SECOND       = 26'd1000;
	localparam sleep_ms_t SLEEP_MS_RESET      = 26'd30000;
	localparam timeout_t  MOTION_TIMEOUT_RESET = 24'd60000;

	localparam level_t LEVEL_OFF  = 13'd0;
	localparam level_t LEVEL_MIN  = 13'd80;
	localparam level_t LEVEL_FULL = 13'd4096;
	localparam level_t LEVEL_STEP = 13'd2;
	localparam level_t LEVEL_BAND = 13'd128;
	localparam logic [LIGHT_W-1:0] SENSOR_MAX = 12'd4095;

	typedef struct packed {
		logic [ELAPSED_W-1:0] elapsed_ms;
		logic                 touch;
		logic                 wake_request;
		logic                 motion_trigger;
		logic                 motion_level;
		logic                 auto_adjust;
		logic [LIGHT_W-1:0]   light_level;
	} item_t;

	typedef struct packed {
		level_t brightness;
		logic   awake;
		logic   motion_detected;
		logic   motion_woke;
		logic   went_dark;
	} result_t;

	typedef struct packed {
		sleep_ms_t sleep_ms;
		timeout_t  motion_timeout_ms;
	} cfg_t;

	// Split the input tdata word into its fields, lowest field first.
	function automatic item_t unpack_item(input logic [IN_TDATA_W-1:0] d);
		item_t it;
		it.elapsed_ms     = d[9:0];
		it.touch          = d[10];
		it.wake_request   = d[11];
		it.motion_trigger = d[12];
		it.motion_level   = d[13];
		it.auto_adjust    = d[14];
		it.light_level    = d[26:15];
		return it;
	endfunction

	// Pack a result into the output tdata word, zero filled.
	function automatic logic [OUT_TDATA_W-1:0] pack_result(input result_t r);
		return {7'd0, r.went_dark, r.motion_woke, r.motion_detected, r.awake, r.brightness};
	endfunction

endpackage

`default_nettype wire

/* hdl/bswc_cfg.sv */
// Configuration registers; the sleep time is kept in milliseconds.
`default_nettype none

module bswc_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [0:0]                      cfg_index,
	input  wire logic [bswc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output bswc_pkg::cfg_t                       cfg
);

	bswc_pkg::sleep_ms_t sleep_ms_q;
	bswc_pkg::timeout_t  timeout_q;

	// Scale seconds to milliseconds once, at write time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_ms_q <= bswc_pkg::SLEEP_MS_RESET;
			timeout_q  <= bswc_pkg::MOTION_TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bswc_pkg::CFG_SLEEP_SECONDS: begin
					sleep_ms_q <= {10'd0, cfg_wdata[bswc_pkg::SLEEP_S_W-1:0]}
						* bswc_pkg::MS_PER_SECOND;
				end
				bswc_pkg::CFG_MOTION_TIMEOUT_MS: begin
					timeout_q <= cfg_wdata[bswc_pkg::TIMEOUT_W-1:0];
				end
				default: begin
					timeout_q <= timeout_q;
				end
			endcase
		end
	end

	assign cfg.sleep_ms          = sleep_ms_q;
	assign cfg.motion_timeout_ms = timeout_q;

endmodule

`default_nettype wire

/* hdl/bswc_level_step.sv */
// One auto-brightness step toward the scaled light reading.
`default_nettype none

module bswc_level_step (
	input  wire logic                         auto_adjust,
	input  wire logic [bswc_pkg::LIGHT_W-1:0] light_level,
	input  wire bswc_pkg::level_t             level_in,
	output bswc_pkg::level_t                  level_out
);

	bswc_pkg::level_t target;
	bswc_pkg::level_t gap;
	logic             step_en;

	// light*4096/4095 truncated equals light, plus one at full scale
	always_comb begin
		target = {1'b0, light_level}
			+ bswc_pkg::level_t'(light_level == bswc_pkg::SENSOR_MAX);
		gap = (level_in > target) ? level_in - target : target - level_in;
		step_en = auto_adjust && ((gap > bswc_pkg::LEVEL_BAND) ||
			(level_in == bswc_pkg::LEVEL_OFF));
	end

	// Step by two and clamp to the valid range
	always_comb begin
		level_out = level_in;
		if (step_en) begin
			if (level_in > target) begin
				if (level_in < bswc_pkg::LEVEL_MIN + bswc_pkg::LEVEL_STEP) begin
					level_out = bswc_pkg::LEVEL_MIN;
				end else begin
					level_out = level_in - bswc_pkg::LEVEL_STEP;
				end
			end else begin
				if (level_in < bswc_pkg::LEVEL_MIN - bswc_pkg::LEVEL_STEP) begin
					level_out = bswc_pkg::LEVEL_MIN;
				end else if (level_in > bswc_pkg::LEVEL_FULL - bswc_pkg::LEVEL_STEP) begin
					level_out = bswc_pkg::LEVEL_FULL;
				end else begin
					level_out = level_in + bswc_pkg::LEVEL_STEP;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/bswc_core.sv */
// Controller state and its per-pass update.
`default_nettype none

module bswc_core #(
	parameter int TIME_BITS = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire bswc_pkg::item_t item,
	input  wire bswc_pkg::cfg_t  cfg,
	output bswc_pkg::result_t    result
);

	// Ages replace stamps: age = (clock - stamp) mod 2^TIME_BITS
	logic [TIME_BITS-1:0] clock_q, touch_age_q, motion_age_q;
	bswc_pkg::level_t     level_q;
	logic                 awake_q, timer_q, flag_q;

	logic [TIME_BITS-1:0] clock_n, touch_age_n, motion_age_n, touch_age_adv;
	bswc_pkg::level_t     level_pre, level_n;
	logic                 awake_n, timer_n, flag_n, woke, dark, sleep_due;

	// Apply one pass in model order
	always_comb begin
		clock_n       = clock_q + TIME_BITS'(item.elapsed_ms);
		touch_age_adv = touch_age_q + TIME_BITS'(item.elapsed_ms);
		motion_age_n  = motion_age_q + TIME_BITS'(item.elapsed_ms);
		touch_age_n   = touch_age_adv;
		level_pre     = level_q;
		awake_n       = awake_q;
		timer_n       = timer_q;
		flag_n        = flag_q;
		woke          = 1'b0;
		dark          = 1'b0;

		// Touch and wake request restart the inactivity time
		if (item.touch || item.wake_request) begin
			touch_age_n = '0;
		end
		if (item.wake_request) begin
			timer_n   = 1'b1;
			level_pre = bswc_pkg::LEVEL_FULL;
			awake_n   = 1'b1;
		end

		// Sleep check; a cleared stamp makes the age equal the clock
		sleep_due = !(item.touch || item.wake_request) &&
			(touch_age_adv > TIME_BITS'(cfg.sleep_ms));
		if (sleep_due && !item.motion_trigger && !item.motion_level) begin
			touch_age_n = clock_n;
			if (timer_n) begin
				level_pre = bswc_pkg::LEVEL_OFF;
				timer_n   = 1'b0;
				awake_n   = 1'b0;
				dark      = 1'b1;
			end
		end

		// Motion while asleep
		if (item.motion_trigger && !awake_n) begin
			motion_age_n = '0;
			flag_n       = 1'b1;
			if (!timer_n) begin
				timer_n     = 1'b1;
				touch_age_n = '0;
				level_pre   = bswc_pkg::LEVEL_FULL;
				awake_n     = 1'b1;
				woke        = 1'b1;
			end
		end

		// Motion status clears after the timeout with the pin low
		if (flag_n && !item.motion_level &&
				(motion_age_n > TIME_BITS'(cfg.motion_timeout_ms))) begin
			flag_n = 1'b0;
		end
	end

	bswc_level_step u_level_step (
		.auto_adjust (item.auto_adjust),
		.light_level (item.light_level),
		.level_in    (level_pre),
		.level_out   (level_n)
	);

	// Commit state when the pass moves to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q      <= '0;
			touch_age_q  <= '0;
			motion_age_q <= '0;
			level_q      <= bswc_pkg::LEVEL_FULL;
			awake_q      <= 1'b1;
			timer_q      <= 1'b1;
			flag_q       <= 1'b0;
		end else if (advance) begin
			clock_q      <= clock_n;
			touch_age_q  <= touch_age_n;
			motion_age_q <= motion_age_n;
			level_q      <= level_n;
			awake_q      <= awake_n;
			timer_q      <= timer_n;
			flag_q       <= flag_n;
		end
	end

	assign result.brightness      = level_n;
	assign result.awake           = awake_n;
	assign result.motion_detected = flag_n;
	assign result.motion_woke     = woke;
	assign result.went_dark       = dark;

endmodule

`default_nettype wire

/* hdl/backlight_sleep_wake_controller.sv */
// Top level of the backlight sleep/wake controller.
// Each input transaction is one pass of the display control loop and gives
// exactly one result transaction with the brightness and status after it.
// Input stream s_axis: tvalid/tready/tdata, output stream m_axis the same.
// A transaction moves when tvalid and tready are both high at a clock edge.
// The cfg port writes sleep_seconds (index 0) or motion_timeout_ms (index 1)
// on any edge with cfg_we high; write it only while no pass is in flight.
// An accepted item is held in the input register and its result is registered
// before m_axis shows it. Throughput: one item per cycle while m_axis_tready
// stays high; the state update is add, compare and select between the registers.
// The output register parts the two sides: while a result waits, one more
// item is taken into the input register and holds there until the receiver
// takes the result. Asynchronous reset (arst_n low) empties both registers
// and puts the display awake at full brightness with the clock, the
// inactivity and motion timers at zero and the motion flag clear; the
// configuration returns to 30 s sleep and a 60000 ms motion timeout.
`default_nettype none

module backlight_sleep_wake_controller #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [9:0] elapsed_ms, [10] touch, [11] wake_request, [12] motion_trigger,
	// [13] motion_level, [14] auto_adjust, [26:15] light_level, rest zero
	input  wire logic [bswc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [12:0] brightness, [13] awake, [14] motion_detected, [15] motion_woke,
	// [16] went_dark, rest zero
	output logic [bswc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	input  wire logic                             cfg_we,
	input  wire logic [0:0]                       cfg_index,
	input  wire logic [bswc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	bswc_pkg::item_t   item_s1;
	logic              valid_s1;
	logic [bswc_pkg::OUT_TDATA_W-1:0] tdata_s2;
	logic              valid_s2;
	logic              advance;
	bswc_pkg::cfg_t    cfg;
	bswc_pkg::result_t result;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	bswc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bswc_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// Hold the accepted transaction until the core takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= bswc_pkg::unpack_item(s_axis_tdata);
		end
	end

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tdata_s2 <= bswc_pkg::pack_result(result);
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = tdata_s2;

endmodule

`default_nettype wire

/* hdl/bswc_checker.sv */
// Port-level checks for the backlight sleep/wake controller, bound to the top.
`default_nettype none
`include "backlight_sleep_wake_controller_macros.svh"

module bswc_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [bswc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// A stalled result holds its value
	`BSWC_ASSERT_RST(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

	// Brightness never exceeds full scale
	`BSWC_ASSERT_RST(a_level_range, clk, arst_n, m_axis_tvalid |-> (m_axis_tdata[12:0] <= bswc_pkg::LEVEL_FULL), "brightness above full scale")

	// A motion wake leaves the display awake with motion flagged, never dark
	`BSWC_ASSERT_RST(a_woke_state, clk, arst_n, m_axis_tvalid && m_axis_tdata[15] |-> m_axis_tdata[13] && m_axis_tdata[14] && !m_axis_tdata[16], "motion wake without awake and motion status")

	// No result is shown after reset is sampled low
	`BSWC_ASSERT(a_reset_empty, clk, !arst_n |=> !m_axis_tvalid, "result valid after reset")

	// Going dark leaves the display asleep
	`BSWC_ASSERT_RST(a_dark_state, clk, arst_n, m_axis_tvalid && m_axis_tdata[16] |-> !m_axis_tdata[13], "went dark but still awake")

endmodule

bind backlight_sleep_wake_controller bswc_checker u_bswc_checker (.*);

`default_nettype wire
